[hw/rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; used by every file under hw/rtl.
package ple_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int POS_W      = 5;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [POS_W-1:0] NO_INDEX = '1;

	typedef enum logic [2:0] {
		ACT_INSERT   = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_GET      = 3'd2,
		ACT_INDEX_OF = 3'd3,
		ACT_CLEAR    = 3'd4
	} ple_action_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic                  insert;
		logic                  remove;
		logic [CMP_W-1:0]      pos;
		logic [CMP_W-1:0]      count;
		logic [VALUE_BITS-1:0] elem;
	} ple_cmd_t;

	// per-cell answers gathered by the top level
	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] rd;
	} ple_cell_out_t;

endpackage

[hw/rtl/ple_cell.sv]
// One slot of the list row: holds an entry, shifts with its neighbors.
// Depends on ple_pkg.
module ple_cell (
	input  logic                           clk,
	input  logic [ple_pkg::IDX_W-1:0]      idx,
	input  ple_pkg::ple_cmd_t              cmd,
	input  logic [ple_pkg::VALUE_BITS-1:0] prev_entry,
	input  logic [ple_pkg::VALUE_BITS-1:0] next_entry,
	output logic [ple_pkg::VALUE_BITS-1:0] entry,
	output ple_pkg::ple_cell_out_t         res
);

	logic [ple_pkg::VALUE_BITS-1:0] entry_q;
	logic [ple_pkg::CMP_W-1:0]      idx_x;
	logic                           at_pos;
	logic                           above_pos;
	logic                           live;

	assign idx_x     = ple_pkg::CMP_W'(idx);
	assign at_pos    = (idx_x == cmd.pos);
	assign above_pos = (idx_x > cmd.pos);
	assign live      = (idx_x < cmd.count);

	// entries are undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (above_pos) begin
				entry_q <= prev_entry;
			end else if (at_pos) begin
				entry_q <= cmd.elem;
			end
		end else if (cmd.remove && (at_pos || above_pos)) begin
			entry_q <= next_entry;
		end
	end

	assign entry   = entry_q;
	assign res.hit = live && (entry_q == cmd.elem);
	assign res.rd  = at_pos ? entry_q : '0;

endmodule

[hw/rtl/positional_list_engine_core.sv]
// Top level of the positional list engine: request/result registers, count,
// and a row of ple_cell slots. Depends on ple_pkg and ple_cell.
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready action position element | request item
//  out     | out_valid out_ready ok value found_index   | result item
//          | count                                     |
//
// Each item is latched in the request register; once the result register is
// free or read out, the whole row shifts or compares at once and it loads.
// A new item is taken as soon as the request register is free, even while a
// result waits on out_ready; a stalled result holds the request stage.
// Reset empties the list (count 0); entry contents are not cleared.
module positional_list_engine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  action,
	input  logic [ple_pkg::POS_W-1:0]   position,
	input  logic [31:0]                 element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic [ple_pkg::VALUE_W-1:0] value,
	output logic signed [4:0]           found_index,
	output logic [4:0]                  count
);

	localparam int N = ple_pkg::CAPACITY;

	logic                           req_v_q;
	logic [2:0]                     act_q;
	logic [ple_pkg::POS_W-1:0]      pos_q;
	logic [ple_pkg::VALUE_BITS-1:0] elem_q;
	logic [ple_pkg::CNT_W-1:0]      count_q;

	logic                        out_v_q;
	logic                        ok_q;
	logic [ple_pkg::VALUE_W-1:0] value_q;
	logic [4:0]                  found_q;
	logic [4:0]                  count_out_q;

	logic                           exec;
	logic                           ok_c;
	logic                           do_ins;
	logic                           do_rem;
	logic [ple_pkg::VALUE_BITS-1:0] value_c;
	logic [4:0]                     found_c;
	logic [ple_pkg::CNT_W-1:0]      count_c;
	logic [ple_pkg::CMP_W-1:0]      pos_x;
	logic [ple_pkg::CMP_W-1:0]      cnt_x;
	logic [ple_pkg::VALUE_BITS-1:0] rd_any;
	logic [N-1:0]                   hits;
	logic [4:0]                     first_hit;

	ple_pkg::ple_cmd_t                           cmd;
	ple_pkg::ple_cell_out_t [N-1:0]              cres;
	logic [N-1:0][ple_pkg::VALUE_BITS-1:0]       ent;

	assign in_ready = !req_v_q;
	assign exec     = req_v_q && (!out_v_q || out_ready);
	assign pos_x    = ple_pkg::CMP_W'(pos_q);
	assign cnt_x    = ple_pkg::CMP_W'(count_q);

	assign cmd.insert = exec && do_ins;
	assign cmd.remove = exec && do_rem;
	assign cmd.pos    = pos_x;
	assign cmd.count  = cnt_x;
	assign cmd.elem   = elem_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		ple_cell u_cell (
			.clk        (clk),
			.idx        (ple_pkg::IDX_W'(i)),
			.cmd        (cmd),
			.prev_entry ((i == 0) ? elem_q : ent[(i == 0) ? 0 : i - 1]),
			.next_entry ((i == N - 1) ? elem_q : ent[(i == N - 1) ? i : i + 1]),
			.entry      (ent[i]),
			.res        (cres[i])
		);
		assign hits[i] = cres[i].hit;
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < N; i++) begin
			rd_any = rd_any | cres[i].rd;
		end
	end

	// lowest matching slot wins
	always_comb begin
		first_hit = ple_pkg::NO_INDEX;
		for (int i = N - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first_hit = 5'(i);
			end
		end
	end

	always_comb begin
		ok_c    = 1'b0;
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		value_c = '0;
		found_c = ple_pkg::NO_INDEX;
		count_c = count_q;
		unique case (act_q)
			ple_pkg::ACT_INSERT: begin
				ok_c   = (pos_x <= cnt_x) && (count_q < ple_pkg::CNT_W'(N));
				do_ins = ok_c;
				if (ok_c) begin
					count_c = count_q + 1'b1;
				end
			end
			ple_pkg::ACT_REMOVE: begin
				ok_c   = (pos_x < cnt_x);
				do_rem = ok_c;
				if (ok_c) begin
					value_c = rd_any;
					count_c = count_q - 1'b1;
				end
			end
			ple_pkg::ACT_GET: begin
				ok_c = (pos_x < cnt_x);
				if (ok_c) begin
					value_c = rd_any;
				end
			end
			ple_pkg::ACT_INDEX_OF: begin
				ok_c    = 1'b1;
				found_c = first_hit;
			end
			ple_pkg::ACT_CLEAR: begin
				ok_c    = 1'b1;
				count_c = '0;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_q <= 1'b0;
			out_v_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				req_v_q <= 1'b1;
			end else if (exec) begin
				req_v_q <= 1'b0;
			end
			if (exec) begin
				out_v_q <= 1'b1;
				count_q <= count_c;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= action;
			pos_q  <= position;
			elem_q <= element[ple_pkg::VALUE_BITS-1:0];
		end
		if (exec) begin
			ok_q        <= ok_c;
			value_q     <= ple_pkg::VALUE_W'(value_c);
			found_q     <= found_c;
			count_out_q <= 5'(count_c);
		end
	end

	assign out_valid   = out_v_q;
	assign ok          = ok_q;
	assign value       = value_q;
	assign found_index = found_q;
	assign count       = count_out_q;

endmodule

[hw/rtl/ple_chk.sv]
// Port-level checks for positional_list_engine_core, bound to the top level.
// Depends on ple_pkg.
module ple_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        ok,
	input logic [ple_pkg::VALUE_W-1:0] value,
	input logic signed [4:0]           found_index,
	input logic [4:0]                  count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(count))
		else $error("result changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(count) <= ple_pkg::CAPACITY)
		else $error("count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> value == '0)
		else $error("failed item returned a value");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_index != ple_pkg::NO_INDEX |->
			ok && $unsigned(found_index) < count)
		else $error("found index outside list");

endmodule

bind positional_list_engine_core ple_chk u_ple_chk (.*);

[dv/positional_list_engine_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine_core: directed table, then random
// insert/remove/get/index_of/clear traffic checked against a behavioral list model.
// Depends on ple_pkg and the RTL under hw/rtl.
module positional_list_engine_core_tb;
	import ple_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 520;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;

	// action codes the block does not implement
	localparam logic [2:0] ACT_RSVD_A = 3'd5;
	localparam logic [2:0] ACT_RSVD_B = 3'd6;
	localparam logic [2:0] ACT_RSVD_C = 3'd7;

	typedef struct packed {
		logic                    ok;
		logic [VALUE_W-1:0]      value;
		logic [POS_W-1:0]        found_index;
		logic [4:0]              count;
	} list_result_t;

	typedef struct {
		logic [2:0]       act;
		logic [POS_W-1:0] pos;
		logic [31:0]      elem;
		bit               typed;
		list_result_t     res;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [2:0]                action = '0;
	logic [POS_W-1:0]          position = '0;
	logic [31:0]               element = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      ok;
	logic [VALUE_W-1:0]        value;
	logic signed [4:0]         found_index;
	logic [4:0]                count;

	// shadow copy of the list
	logic [VALUE_BITS-1:0] shadow_entries [CAPACITY];
	int                    shadow_count = 0;

	list_result_t pending_results [$];
	stim_row_t    directed_rows [$];

	int mismatches     = 0;
	int results_seen   = 0;
	int inserts_done   = 0;
	int removes_done   = 0;
	int full_rejects   = 0;
	int key_hits       = 0;
	int clears_done    = 0;
	int rejects_other  = 0;
	int burst_left     = 0;
	int stall_left     = 0;
	int stall_mode     = 0;
	int idle_cycles    = 0;
	int rx_cycle       = 0;

	positional_list_engine_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.position    (position),
		.element     (element),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.value       (value),
		.found_index (found_index),
		.count       (count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic list_result_t list_apply(logic [2:0] act, logic [POS_W-1:0] pos,
			logic [31:0] key);
		list_result_t res;
		int           at;
		int           i;
		res = '{ok: 1'b0, value: '0, found_index: NO_INDEX, count: '0};
		at = int'(pos);
		case (act)
		ACT_INSERT: begin
			if (at <= shadow_count && shadow_count < CAPACITY) begin
				for (i = shadow_count; i > at; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[at] = key[VALUE_BITS-1:0];
				shadow_count++;
				res.ok = 1'b1;
			end
		end
		ACT_REMOVE: begin
			if (at < shadow_count) begin
				res.value = shadow_entries[at];
				for (i = at; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
				res.ok = 1'b1;
			end
		end
		ACT_GET: begin
			if (at < shadow_count) begin
				res.value = shadow_entries[at];
				res.ok = 1'b1;
			end
		end
		ACT_INDEX_OF: begin
			res.ok = 1'b1;
			for (i = shadow_count - 1; i >= 0; i--)
				if (shadow_entries[i] == key[VALUE_BITS-1:0])
					res.found_index = POS_W'(i);
		end
		ACT_CLEAR: begin
			shadow_count = 0;
			res.ok = 1'b1;
		end
		default: ;
		endcase
		res.count = 5'(shadow_count);
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic add_row(input logic [2:0] a, input logic [POS_W-1:0] p, input logic [31:0] e,
			input bit typed, input logic exp_ok, input logic [4:0] exp_count);
		stim_row_t row;
		row.act = a;
		row.pos = p;
		row.elem = e;
		row.typed = typed;
		row.res = '{ok: exp_ok, value: '0, found_index: NO_INDEX, count: exp_count};
		directed_rows.push_back(row);
	endtask

	// sender bursts: a new burst may start after a random gap
	task automatic sender_idle();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// called right after a rising edge; returns right after the accepting edge
	task automatic drive_request(input logic [2:0] a, input logic [POS_W-1:0] p,
			input logic [31:0] e, input bit typed, input list_result_t typed_res);
		list_result_t predicted;
		action   <= a;
		position <= p;
		element  <= e;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = list_apply(a, p, e);
		pending_results.push_back(typed ? typed_res : predicted);
		if (a == ACT_INSERT && predicted.ok)
			inserts_done++;
		else if (a == ACT_INSERT && shadow_count == CAPACITY)
			full_rejects++;
		else if (a == ACT_REMOVE && predicted.ok)
			removes_done++;
		else if (a == ACT_INDEX_OF && predicted.found_index != NO_INDEX)
			key_hits++;
		else if (a == ACT_CLEAR)
			clears_done++;
		else if (!predicted.ok)
			rejects_other++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2, 3: return 32'(($urandom_range(1, 4)));
		default: return $urandom();
		endcase
	endfunction

	task automatic pick_request(input bit grow, output logic [2:0] a, output logic [POS_W-1:0] p,
			output logic [31:0] e);
		int r;
		int hi;
		r = $urandom_range(0, 99);
		if (r < (grow ? 45 : 22))
			a = ACT_INSERT;
		else if (r < 60)
			a = ACT_REMOVE;
		else if (r < 75)
			a = ACT_GET;
		else if (r < 91)
			a = ACT_INDEX_OF;
		else if (r < 94)
			a = ACT_CLEAR;
		else
			a = 3'($urandom_range(0, 7));
		hi = (a == ACT_INSERT) ? shadow_count : shadow_count - 1;
		if (hi >= 0 && $urandom_range(0, 99) < 85)
			p = POS_W'($urandom_range(0, hi));
		else
			p = POS_W'($urandom_range(0, 31));
		e = pick_value();
		// bias keys toward values actually held
		if (a == ACT_INDEX_OF && shadow_count > 0 && $urandom_range(0, 1) == 1)
			e = shadow_entries[$urandom_range(0, shadow_count - 1)];
	endtask

	// receiver: check results and stall on its own schedule
	always @(posedge clk) begin
		list_result_t want;
		rx_cycle++;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending: ok=%0b value=%h idx=%0d cnt=%0d",
					ok, value, found_index, count));
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (ok !== want.ok)
					flag_mismatch($sformatf("result %0d ok %0b, want %0b", results_seen, ok, want.ok));
				if (value !== want.value)
					flag_mismatch($sformatf("result %0d value %h, want %h", results_seen, value,
						want.value));
				if (found_index !== want.found_index)
					flag_mismatch($sformatf("result %0d found_index %0d, want %0d", results_seen,
						found_index, $signed(want.found_index)));
				if (count !== want.count)
					flag_mismatch($sformatf("result %0d count %0d, want %0d", results_seen, count,
						want.count));
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(30, 200);
		end
		stall_left--;
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= 1'($urandom_range(0, 1));
		2: out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= (rx_cycle % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles, %0d results pending", IDLE_LIMIT,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [2:0]       a;
		logic [POS_W-1:0] p;
		logic [31:0]      e;
		list_result_t     unused_res;
		logic [31:0]      fill_val;

		unused_res = '0;

		// empty list corner cases
		add_row(ACT_GET,      5'd0,  32'h0,         1'b1, 1'b0, 5'd0);
		add_row(ACT_INDEX_OF, 5'd0,  32'h0,         1'b1, 1'b1, 5'd0);
		add_row(ACT_REMOVE,   5'd0,  32'h0,         1'b1, 1'b0, 5'd0);
		add_row(ACT_INSERT,   5'd31, 32'h1,         1'b1, 1'b0, 5'd0);
		// fill to capacity at front, back and middle
		for (int i = 0; i < CAPACITY; i++) begin
			case (i)
			0: fill_val = 32'hFFFF_FFFF;
			1, 9: fill_val = 32'h0000_0000;
			2: fill_val = 32'h8000_0001;
			default: fill_val = 32'h5A00_0000 | i;
			endcase
			add_row(ACT_INSERT, (i % 3 == 0) ? 5'd0 : (i % 3 == 1) ? POS_W'(i) : POS_W'(i / 2),
				fill_val, 1'b1, 1'b1, 5'(i + 1));
		end
		add_row(ACT_INSERT,   5'd0,  32'h1234_5678, 1'b1, 1'b0, 5'd16);
		add_row(ACT_INSERT,   5'd16, 32'h1234_5678, 1'b1, 1'b0, 5'd16);
		add_row(ACT_INDEX_OF, 5'd0,  32'h0,         1'b0, 1'b0, 5'd0);
		add_row(ACT_REMOVE,   5'd15, 32'h0,         1'b0, 1'b0, 5'd0);
		add_row(ACT_REMOVE,   5'd0,  32'h0,         1'b0, 1'b0, 5'd0);
		add_row(ACT_RSVD_A,   5'd0,  32'h0,         1'b1, 1'b0, 5'd14);
		add_row(ACT_RSVD_B,   5'd1,  32'hFFFF_FFFF, 1'b1, 1'b0, 5'd14);
		add_row(ACT_RSVD_C,   5'd31, 32'h0,         1'b1, 1'b0, 5'd14);
		add_row(ACT_CLEAR,    5'd0,  32'h0,         1'b1, 1'b1, 5'd0);
		// stale contents must not match after a clear
		add_row(ACT_INDEX_OF, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			sender_idle();
			drive_request(directed_rows[k].act, directed_rows[k].pos, directed_rows[k].elem,
				directed_rows[k].typed, directed_rows[k].res);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the block has drained
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				@(posedge clk);
			end else begin
				sender_idle();
			end
			pick_request(((n / 60) % 2) == 0, a, p, e);
			drive_request(a, p, e, 1'b0, unused_res);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("items: %0d directed + %0d random, %0d results checked, %0d mismatches",
			directed_rows.size(), RANDOM_ITEMS, results_seen, mismatches);
		$display("inserts %0d, full rejects %0d, removes %0d, key hits %0d, clears %0d, other rejects %0d",
			inserts_done, full_rejects, removes_done, key_hits, clears_done, rejects_other);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_core.sv
hw/rtl/ple_chk.sv
dv/positional_list_engine_core_tb.sv
